// ===== hw/rtl/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and constants of the countdown timer bank: item codes,
// command and timer-entry layouts, configuration register map and the
// back-end state encoding.
// ----------------------------------------------------------------------------
package ctb_pkg;

  // Field widths of one request and one result.
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 3;
  localparam int COUNT_W  = 32;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Depth of the command queue between the front and the back end.
  localparam int CMD_DEPTH   = 4;
  localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] MS_STEP_RESET = 8'd8;
  localparam logic [CFG_W-1:0] TPS_RESET     = 8'd125;

  // Timer unit codes.
  localparam logic UNIT_SECONDS  = 1'b0;
  localparam logic UNIT_MSECONDS = 1'b1;

  // Request modes as they arrive on the input channel.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_READ    = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MS_STEP          = 2'd0,
    CFG_TICKS_PER_SECOND = 2'd1
  } cfg_reg_t;

  // Commands after classification by the front end.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_RESTART,
    OP_READ,
    OP_READ_NULL
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [INDEX_W-1:0]  idx;
    logic [COUNT_W-1:0]  value;
    logic                unit;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  // One stored timer.
  typedef struct packed {
    logic               unit;
    logic               active;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Live configuration seen by the back end.
  typedef struct packed {
    logic [CFG_W-1:0] ms_step;
    logic [CFG_W-1:0] ticks_per_second;
  } cfg_regs_t;

  // Back-end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_SWEEP
  } bk_state_t;

endpackage

// ===== hw/rtl/ctb_item_if.sv =====
// ----------------------------------------------------------------------------
// ctb_item_if
// Request channel of the timer bank: valid/ready plus one request payload.
// ----------------------------------------------------------------------------
interface ctb_item_if;
  logic                          valid;
  logic                          ready;
  logic [ctb_pkg::MODE_W-1:0]    mode;
  logic [ctb_pkg::INDEX_W-1:0]   timer_index;
  logic [ctb_pkg::COUNT_W-1:0]   time_value;
  logic                          time_unit;

  modport source (output valid, output mode, output timer_index, output time_value,
                  output time_unit, input ready);
  modport sink   (input valid, input mode, input timer_index, input time_value,
                  input time_unit, output ready);
endinterface

// ===== hw/rtl/ctb_result_if.sv =====
// ----------------------------------------------------------------------------
// ctb_result_if
// Result channel of the timer bank: valid/ready plus the read-back payload.
// ----------------------------------------------------------------------------
interface ctb_result_if;
  logic                        valid;
  logic                        ready;
  logic [ctb_pkg::COUNT_W-1:0] count_value;
  logic                        is_active;

  modport source (output valid, output count_value, output is_active, input ready);
  modport sink   (input valid, input count_value, input is_active, output ready);
endinterface

// ===== hw/rtl/ctb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ctb_cfg_if
// Configuration write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
interface ctb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ctb_pkg::CFG_IDX_W-1:0] index;
  logic [ctb_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ctb_ram.sv =====
// ----------------------------------------------------------------------------
// ctb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ctb_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/ctb_front.sv =====
// ----------------------------------------------------------------------------
// ctb_front
// Request front end: takes requests while the queue has room, drops
// requests that change nothing and turns the rest into back-end commands.
// ----------------------------------------------------------------------------
module ctb_front #(
  parameter int NUM_TIMERS = 8
) (
  ctb_item_if.sink              item,
  input  logic                  queue_full,
  output ctb_pkg::cmd_push_t    push
);

  logic in_range;
  logic accept;

  assign item.ready = !queue_full;
  assign accept     = item.valid && !queue_full;
  assign in_range   = (int'(item.timer_index) < NUM_TIMERS);

  // Classify the request. An unused mode and a restart of a missing timer
  // are dropped here; a read of a missing timer becomes a null read.
  always_comb begin
    push.valid     = 1'b0;
    push.cmd.op    = ctb_pkg::OP_TICK;
    push.cmd.idx   = item.timer_index;
    push.cmd.value = item.time_value;
    push.cmd.unit  = item.time_unit;
    unique case (ctb_pkg::mode_t'(item.mode))
      ctb_pkg::MODE_TICK: begin
        push.valid  = accept;
        push.cmd.op = ctb_pkg::OP_TICK;
      end
      ctb_pkg::MODE_RESTART: begin
        push.valid  = accept && in_range;
        push.cmd.op = ctb_pkg::OP_RESTART;
      end
      ctb_pkg::MODE_READ: begin
        push.valid  = accept;
        push.cmd.op = in_range ? ctb_pkg::OP_READ : ctb_pkg::OP_READ_NULL;
      end
      default: begin
        push.valid = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ctb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ctb_cmd_fifo
// Short command queue that lets the front and back ends stall separately.
// ----------------------------------------------------------------------------
module ctb_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  ctb_pkg::cmd_push_t  push,
  input  logic                pop,
  output logic                full,
  output ctb_pkg::cmd_head_t  head
);

  ctb_pkg::cmd_t                 slots [ctb_pkg::CMD_DEPTH];
  logic [ctb_pkg::CMD_PTR_W-1:0] wr_ptr;
  logic [ctb_pkg::CMD_PTR_W-1:0] rd_ptr;
  logic [ctb_pkg::CMD_PTR_W:0]   fill;
  logic                          do_push;
  logic                          do_pop;

  assign full     = (fill == (ctb_pkg::CMD_PTR_W+1)'(ctb_pkg::CMD_DEPTH));
  assign do_push  = push.valid && !full;
  assign do_pop   = pop && (fill != '0);
  assign head.valid = (fill != '0);
  assign head.cmd   = slots[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ctb_back.sv =====
// ----------------------------------------------------------------------------
// ctb_back
// Back end: executes queued commands against the timer RAM. A tick walks
// all timers one per cycle as a read-modify-write pipeline; restart and
// read each take one read and one write or capture.
// ----------------------------------------------------------------------------
module ctb_back #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctb_pkg::cfg_regs_t     cfg,
  input  ctb_pkg::cmd_head_t     head,
  output logic                   pop,
  ctb_result_if.source           result
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [AW-1:0] LAST = AW'(NUM_TIMERS - 1);

  ctb_pkg::bk_state_t          state;
  ctb_pkg::bk_state_t          state_next;
  logic [AW-1:0]               ptr;
  logic [AW-1:0]               ptr_next;
  logic [NUM_TIMERS-1:0]       filled;
  logic [ctb_pkg::CFG_W-1:0]   prescaler;
  logic [ctb_pkg::CFG_W-1:0]   pre_inc;
  logic                        sec_pass;

  // RAM ports.
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic                        ram_we;
  logic [ctb_pkg::ENTRY_W-1:0] ram_rdata;
  ctb_pkg::entry_t             wdata;

  // Stage between the RAM read and the write-back.
  logic                        pend_valid;
  ctb_pkg::op_t                pend_op;
  logic [AW-1:0]               pend_addr;
  logic [ctb_pkg::COUNT_W-1:0] pend_value;
  logic                        pend_unit;
  ctb_pkg::entry_t             old;

  // Result register.
  logic                        res_valid;
  logic [ctb_pkg::COUNT_W-1:0] res_count;
  logic                        res_active;

  ctb_ram #(
    .WIDTH (ctb_pkg::ENTRY_W),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_addr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pre_inc = prescaler + 1'b1;

  // Sequencer: pick up a command, issue RAM reads.
  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    pop        = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = ptr;
    unique case (state)
      ctb_pkg::BK_IDLE: begin
        if (head.valid && !pend_valid) begin
          unique case (head.cmd.op)
            ctb_pkg::OP_TICK: begin
              pop        = 1'b1;
              state_next = ctb_pkg::BK_SWEEP;
              ptr_next   = '0;
            end
            ctb_pkg::OP_RESTART: begin
              pop       = 1'b1;
              ram_re    = 1'b1;
              ram_raddr = AW'(head.cmd.idx);
            end
            ctb_pkg::OP_READ: begin
              pop       = !res_valid;
              ram_re    = !res_valid;
              ram_raddr = AW'(head.cmd.idx);
            end
            ctb_pkg::OP_READ_NULL: begin
              pop = !res_valid;
            end
            default: begin
              pop = 1'b0;
            end
          endcase
        end
      end
      ctb_pkg::BK_SWEEP: begin
        ram_re = 1'b1;
        if (ptr == LAST) begin
          state_next = ctb_pkg::BK_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      default: begin
        state_next = ctb_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctb_pkg::BK_IDLE;
      ptr   <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
  end

  // Prescaler: advanced once per tick, decides on the seconds pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler <= '0;
      sec_pass  <= 1'b0;
    end else if (pop && head.cmd.op == ctb_pkg::OP_TICK) begin
      if (pre_inc >= cfg.ticks_per_second) begin
        prescaler <= '0;
        sec_pass  <= 1'b1;
      end else begin
        prescaler <= pre_inc;
        sec_pass  <= 1'b0;
      end
    end
  end

  // Read-to-write stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      pend_addr  <= ram_raddr;
      pend_op    <= (state == ctb_pkg::BK_SWEEP) ? ctb_pkg::OP_TICK : head.cmd.op;
      pend_value <= head.cmd.value;
      pend_unit  <= head.cmd.unit;
    end
  end

  // A timer never written since reset reads as all zero.
  assign old = filled[pend_addr] ? ctb_pkg::entry_t'(ram_rdata) : '0;

  // Updated entry for the write-back.
  always_comb begin
    wdata = old;
    case (pend_op)
      ctb_pkg::OP_RESTART: begin
        wdata.unit   = pend_unit;
        wdata.active = 1'b1;
        if (pend_value != '0) begin
          wdata.count = pend_value;
        end
      end
      ctb_pkg::OP_TICK: begin
        if (old.unit == ctb_pkg::UNIT_MSECONDS) begin
          if (old.active && old.count != '0) begin
            if (old.count >= ctb_pkg::COUNT_W'(cfg.ms_step)) begin
              wdata.count = old.count - ctb_pkg::COUNT_W'(cfg.ms_step);
            end else begin
              wdata.count  = '0;
              wdata.active = 1'b0;
            end
          end
        end else if (sec_pass) begin
          if (old.active && old.count != '0) begin
            wdata.count = old.count - 1'b1;
          end else begin
            wdata.count  = '0;
            wdata.active = 1'b0;
          end
        end
      end
      default: begin
        wdata = old;
      end
    endcase
  end

  assign ram_we = pend_valid && (pend_op == ctb_pkg::OP_TICK || pend_op == ctb_pkg::OP_RESTART);

  // Written flags, one per timer.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (ram_we) begin
      filled[pend_addr] <= 1'b1;
    end
  end

  // Result register: loaded by a read, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pend_valid && pend_op == ctb_pkg::OP_READ) begin
      res_valid <= 1'b1;
    end else if (pop && head.cmd.op == ctb_pkg::OP_READ_NULL) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && pend_op == ctb_pkg::OP_READ) begin
      res_count  <= old.count;
      res_active <= old.active;
    end else if (pop && head.cmd.op == ctb_pkg::OP_READ_NULL) begin
      res_count  <= '0;
      res_active <= 1'b0;
    end
  end

  assign result.valid       = res_valid;
  assign result.count_value = res_count;
  assign result.is_active   = res_active;

endmodule

// ===== hw/rtl/countdown_timer_bank_unit.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_bank_unit
// Bank of countdown timers in milliseconds or seconds, driven by tick,
// restart and read requests.
//
//   channel | dir | handshake   | payload
//   item    | in  | valid/ready | mode, timer_index, time_value, time_unit
//   result  | out | valid/ready | count_value, is_active
//   cfg     | in  | valid/ready | index, data (ms_step, ticks_per_second)
//
// A tick occupies the back end while it is taken, while each timer is read
// in turn from the timer RAM, and until the last write-back is done.
// A restart or read takes one RAM read and one write-back or capture, a
// read of a missing timer no RAM access; dropped requests never reach the
// back end. A read waits until the previous result is taken.
// Requests are queued (four deep) in order, so up to four are taken while a
// result waits; commands behind a waiting read wait as well.
// Reset is synchronous; all timers read as zero and inactive right after
// it through per-timer written flags, with no clearing pass.
// ----------------------------------------------------------------------------
module countdown_timer_bank_unit #(
  parameter int NUM_TIMERS = 8
) (
  input  logic          clk,
  input  logic          rst,
  ctb_item_if.sink      item,
  ctb_result_if.source  result,
  ctb_cfg_if.sink       cfg
);

  ctb_pkg::cfg_regs_t  cfg_regs;
  ctb_pkg::cmd_push_t  push;
  ctb_pkg::cmd_head_t  head;
  logic                queue_full;
  logic                pop;

  // Configuration registers: always writable.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.ms_step          <= ctb_pkg::MS_STEP_RESET;
      cfg_regs.ticks_per_second <= ctb_pkg::TPS_RESET;
    end else if (cfg.valid) begin
      case (ctb_pkg::cfg_reg_t'(cfg.index))
        ctb_pkg::CFG_MS_STEP:          cfg_regs.ms_step          <= cfg.data;
        ctb_pkg::CFG_TICKS_PER_SECOND: cfg_regs.ticks_per_second <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  ctb_front #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_front (
    .item       (item),
    .queue_full (queue_full),
    .push       (push)
  );

  ctb_cmd_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (queue_full),
    .head (head)
  );

  ctb_back #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== hw/rtl/ctb_checker.sv =====
// ----------------------------------------------------------------------------
// ctb_checker
// Port-level checks of the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module ctb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [ctb_pkg::COUNT_W-1:0] count_value,
  input logic                        is_active,
  input logic                        cfg_ready
);

  // No result is pending in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // The request queue can only fill up through an accepted request.
  a_full_by_push: assert property (@(posedge clk) disable iff (rst)
    $fell(item_ready) |-> $past(item_valid && item_ready))
    else $error("request ready dropped without an accepted request");

  // The configuration port never stalls outside reset.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

  // A stalled result keeps its value.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(count_value) && $stable(is_active))
    else $error("stalled result changed");

endmodule

bind countdown_timer_bank_unit ctb_checker u_ctb_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .count_value (result.count_value),
  .is_active   (result.is_active),
  .cfg_ready   (cfg.ready)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the countdown timer bank. Tick, restart and read
// requests go in under bursty, stalling traffic. An in-bench copy of the
// timer state predicts every read, and each returned count and active flag is
// compared with that prediction. Step and prescale settings are swept
// between phases, including zero and full scale.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_TIMERS = 8;
  localparam logic [ctb_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  // Back end holds up to four queued ticks plus one in flight.
  localparam int QUIET_CYCLES = 64;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 110;
  localparam int NUM_PHASES = 5;

  typedef struct {
    logic [ctb_pkg::COUNT_W-1:0] count;
    logic                        active;
  } readback_t;

  logic clk = 1'b0;
  logic rst;

  ctb_item_if   item_ch ();
  ctb_result_if res_ch ();
  ctb_cfg_if    cfg_ch ();

  countdown_timer_bank_unit #(.NUM_TIMERS(NUM_TIMERS)) DUT (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(res_ch),
    .cfg(cfg_ch)
  );

  // Shadow copy of the timer bank and its registers.
  logic [ctb_pkg::COUNT_W-1:0] shadow_count [NUM_TIMERS];
  logic                        shadow_active [NUM_TIMERS];
  logic                        shadow_unit [NUM_TIMERS];
  logic [7:0]                  shadow_prescale;
  logic [ctb_pkg::CFG_W-1:0]   shadow_ms_step;
  logic [ctb_pkg::CFG_W-1:0]   shadow_tps;
  readback_t                   pending_reads [$];

  int error_count = 0;
  int cycle_count = 0;
  int n_ticks = 0;
  int n_restarts = 0;
  int n_reads = 0;
  int n_dropped = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int hold_cycles = 0;
  int burst_left = 0;
  bit pace_on = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d reads outstanding", cycle_count,
               pending_reads.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void reset_shadow();
    for (int k = 0; k < NUM_TIMERS; k++) begin
      shadow_count[k] = '0;
      shadow_active[k] = 1'b0;
      shadow_unit[k] = ctb_pkg::UNIT_SECONDS;
    end
    shadow_prescale = '0;
    shadow_ms_step = ctb_pkg::MS_STEP_RESET;
    shadow_tps = ctb_pkg::TPS_RESET;
  endfunction

  // One tick: millisecond timers step down, then the prescaler may fire a
  // seconds pass over the second-unit timers only.
  function automatic void advance_tick();
    for (int k = 0; k < NUM_TIMERS; k++) begin
      if (shadow_unit[k] == ctb_pkg::UNIT_MSECONDS && shadow_active[k] &&
          shadow_count[k] != '0) begin
        if (shadow_count[k] >= shadow_ms_step) begin
          shadow_count[k] = shadow_count[k] - shadow_ms_step;
        end else begin
          shadow_count[k] = '0;
          shadow_active[k] = 1'b0;
        end
      end
    end
    shadow_prescale = shadow_prescale + 8'd1;
    if (shadow_prescale >= shadow_tps) begin
      shadow_prescale = '0;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        if (shadow_unit[k] == ctb_pkg::UNIT_SECONDS) begin
          if (shadow_active[k] && shadow_count[k] != '0) begin
            shadow_count[k] = shadow_count[k] - 1;
          end else begin
            shadow_count[k] = '0;
            shadow_active[k] = 1'b0;
          end
        end
      end
    end
  endfunction

  // Update the shadow bank for one accepted request.
  function automatic void apply_request(input logic [ctb_pkg::MODE_W-1:0] mode,
                                        input logic [ctb_pkg::INDEX_W-1:0] idx,
                                        input logic [ctb_pkg::COUNT_W-1:0] value,
                                        input logic unit);
    readback_t rb;
    case (mode)
      ctb_pkg::MODE_TICK: begin
        advance_tick();
        n_ticks++;
      end
      ctb_pkg::MODE_RESTART: begin
        if (idx < NUM_TIMERS) begin
          shadow_unit[idx] = unit;
          if (value != '0) shadow_count[idx] = value;
          shadow_active[idx] = 1'b1;
        end
        n_restarts++;
      end
      ctb_pkg::MODE_READ: begin
        rb.count = (idx < NUM_TIMERS) ? shadow_count[idx] : '0;
        rb.active = (idx < NUM_TIMERS) ? shadow_active[idx] : 1'b0;
        pending_reads.push_back(rb);
        n_reads++;
      end
      default: begin
        n_dropped++;
      end
    endcase
  endfunction

  // Offer one request, wait for its handshake, then maybe idle between bursts.
  task automatic send_request(input logic [ctb_pkg::MODE_W-1:0] mode,
                              input logic [ctb_pkg::INDEX_W-1:0] idx,
                              input logic [ctb_pkg::COUNT_W-1:0] value, input logic unit);
    int gap;
    item_ch.valid <= 1'b1;
    item_ch.mode <= mode;
    item_ch.timer_index <= idx;
    item_ch.time_value <= value;
    item_ch.time_unit <= unit;
    do @(posedge clk); while (!item_ch.ready);
    apply_request(mode, idx, value, unit);
    if (pace_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          gap = 0;
          burst_left = $urandom_range(40, 80);
        end else begin
          gap = $urandom_range(1, 7);
          burst_left = $urandom_range(0, 20);
        end
        if (gap > 0) begin
          item_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Stop sending, let every read come back, then let queued ticks finish.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input ctb_pkg::cfg_reg_t which,
                                input logic [ctb_pkg::CFG_W-1:0] data);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (which)
      ctb_pkg::CFG_MS_STEP:          shadow_ms_step = data;
      ctb_pkg::CFG_TICKS_PER_SECOND: shadow_tps = data;
      default: ;
    endcase
    n_cfg++;
  endtask

  // Result receiver: picks among four stall styles at random; a long
  // hold-off is served when a test asks for one.
  initial begin
    int style;
    int style_left;
    style = 0;
    style_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        if (style_left == 0) begin
          style = $urandom_range(0, 3);
          style_left = $urandom_range(8, 60);
        end
        style_left--;
        case (style)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 1) == 1);
          2: res_ch.ready <= ($urandom_range(0, 3) != 0);
          default: res_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Compare each returned read with the oldest prediction.
  always @(posedge clk) begin
    readback_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("read result with no read request outstanding");
      end else begin
        want = pending_reads.pop_front();
        if (res_ch.count_value !== want.count)
          report_mismatch($sformatf("count_value got %0d, want %0d",
                                    res_ch.count_value, want.count));
        if (res_ch.is_active !== want.active)
          report_mismatch($sformatf("is_active got %b, want %b",
                                    res_ch.is_active, want.active));
        n_checked++;
      end
    end
  end

  // Reads straight after reset see cleared timers.
  task automatic test_reset_state();
    send_request(ctb_pkg::MODE_READ, 3'd0, '0, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd7, '1, 1'b1);
  endtask

  // Millisecond countdown at the default step: full-scale count, count equal
  // to the step (rests active at zero), count below the step (cleared),
  // zero restart value keeping the old count, and a dropped unused mode.
  task automatic test_ms_countdown();
    send_request(ctb_pkg::MODE_RESTART, 3'd0, '1, ctb_pkg::UNIT_MSECONDS);
    send_request(ctb_pkg::MODE_RESTART, 3'd1, 32'd8, ctb_pkg::UNIT_MSECONDS);
    send_request(ctb_pkg::MODE_RESTART, 3'd2, 32'd3, ctb_pkg::UNIT_MSECONDS);
    send_request(ctb_pkg::MODE_RESTART, 3'd3, '0, ctb_pkg::UNIT_SECONDS);
    send_request(ctb_pkg::MODE_RESTART, 3'd7, 32'h8000_0000, ctb_pkg::UNIT_SECONDS);
    send_request(MODE_UNUSED, 3'd5, 32'hA5A5_5A5A, 1'b1);
    send_request(ctb_pkg::MODE_TICK, 3'd6, 32'h5A5A_A5A5, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd0, '0, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd1, '0, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd2, '0, 1'b0);
    send_request(ctb_pkg::MODE_TICK, 3'd0, '0, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd1, '0, 1'b0);
    send_request(ctb_pkg::MODE_RESTART, 3'd1, '0, ctb_pkg::UNIT_MSECONDS);
    send_request(ctb_pkg::MODE_READ, 3'd1, '0, 1'b0);
  endtask

  // Full-scale step with a seconds pass at every tick, then zero step and
  // zero prescale, then unit step with full-scale prescale.
  task automatic test_register_extremes();
    write_register(ctb_pkg::CFG_MS_STEP, 8'd255);
    write_register(ctb_pkg::CFG_TICKS_PER_SECOND, 8'd1);
    send_request(ctb_pkg::MODE_RESTART, 3'd4, 32'd2, ctb_pkg::UNIT_SECONDS);
    send_request(ctb_pkg::MODE_RESTART, 3'd5, 32'd300, ctb_pkg::UNIT_MSECONDS);
    send_request(ctb_pkg::MODE_TICK, 3'd0, '0, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd4, '0, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd5, '0, 1'b0);
    send_request(ctb_pkg::MODE_TICK, 3'd0, '0, 1'b0);
    send_request(ctb_pkg::MODE_TICK, 3'd0, '0, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd4, '0, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd3, '0, 1'b0);

    write_register(ctb_pkg::CFG_MS_STEP, 8'd0);
    write_register(ctb_pkg::CFG_TICKS_PER_SECOND, 8'd0);
    send_request(ctb_pkg::MODE_RESTART, 3'd6, 32'd50, ctb_pkg::UNIT_MSECONDS);
    send_request(ctb_pkg::MODE_TICK, 3'd0, '0, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd6, '0, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd7, '0, 1'b0);

    write_register(ctb_pkg::CFG_MS_STEP, 8'd1);
    write_register(ctb_pkg::CFG_TICKS_PER_SECOND, 8'd255);
    send_request(ctb_pkg::MODE_TICK, 3'd0, '0, 1'b0);
    send_request(ctb_pkg::MODE_READ, 3'd6, '0, 1'b0);
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // queue fills and the input stalls; then the sender waits for all reads.
  task automatic test_backpressure();
    pace_on = 1'b0;
    hold_cycles = 300;
    for (int n = 0; n < 40; n++) begin
      if ($urandom_range(0, 9) < 6)
        send_request(ctb_pkg::MODE_READ, 3'($urandom_range(0, 7)), $urandom, 1'($urandom));
      else
        send_request(ctb_pkg::MODE_TICK, 3'($urandom_range(0, 7)), $urandom, 1'($urandom));
    end
    pace_on = 1'b1;
    wait_idle();
  endtask

  function automatic logic [ctb_pkg::COUNT_W-1:0] pick_count();
    int sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  // Random traffic over several register settings.
  task automatic test_random_traffic();
    logic [ctb_pkg::CFG_W-1:0] step_set [NUM_PHASES];
    logic [ctb_pkg::CFG_W-1:0] tps_set [NUM_PHASES];
    int start;
    int pick;
    step_set = '{8'd1, 8'd255, 8'd0, 8'd0, ctb_pkg::MS_STEP_RESET};
    tps_set = '{8'd2, 8'd1, 8'd0, 8'd0, ctb_pkg::TPS_RESET};
    step_set[3] = 8'($urandom_range(1, 255));
    tps_set[3] = 8'($urandom_range(1, 6));
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_register(ctb_pkg::CFG_MS_STEP, step_set[ph]);
      write_register(ctb_pkg::CFG_TICKS_PER_SECOND, tps_set[ph]);
      start = n_ticks + n_restarts + n_reads;
      while (n_ticks + n_restarts + n_reads - start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          send_request(ctb_pkg::MODE_TICK, 3'($urandom), $urandom, 1'($urandom));
        else if (pick < 70)
          send_request(ctb_pkg::MODE_RESTART, 3'($urandom), pick_count(), 1'($urandom));
        else if (pick < 95)
          send_request(ctb_pkg::MODE_READ, 3'($urandom), $urandom, 1'($urandom));
        else
          send_request(MODE_UNUSED, 3'($urandom), $urandom, 1'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.mode = ctb_pkg::MODE_TICK;
    item_ch.timer_index = '0;
    item_ch.time_value = '0;
    item_ch.time_unit = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ctb_pkg::CFG_MS_STEP;
    cfg_ch.data = '0;
    reset_shadow();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_ms_countdown();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (pending_reads.size() != 0)
      report_mismatch($sformatf("%0d reads never returned", pending_reads.size()));
    $display("Checked %0d reads after %0d ticks and %0d restarts; %0d unused requests dropped.",
             n_checked, n_ticks, n_restarts, n_dropped);
    $display("%0d register writes swept step and prescale from zero to full scale.", n_cfg);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
